// ----- hw/rtl/flt_pkg.sv -----
// Shared types and constants for the Forth line tokenizer.
// No dependencies; imported by flt_lexer and forth_line_tokenizer_core.
package flt_pkg;

  localparam int unsigned LineMax = 4096;
  localparam int unsigned PosW    = 12;
  localparam int unsigned PosCapI = ((LineMax - 1) < 4095) ? (LineMax - 1) : 4095;
  localparam logic [PosW-1:0] PosCap = PosW'(PosCapI);

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChDot   = 8'h2E;

  typedef enum logic [1:0] {
    MODE_SKIP   = 2'd0,
    MODE_WORD   = 2'd1,
    MODE_DQSKIP = 2'd2,
    MODE_STRING = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_WORD     = 3'd0,
    KIND_DOTQUOTE = 3'd1,
    KIND_BODY     = 3'd2,
    KIND_EMPTY    = 3'd3,
    KIND_ERROR    = 3'd4
  } kind_e;

  typedef struct packed {
    logic            valid;
    kind_e           kind;
    logic [PosW-1:0] tok_start;
    logic [PosW-1:0] tok_end;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf) || (c == ChVt);
  endfunction

endpackage

// ----- hw/rtl/flt_lexer.sv -----
// Lexer state and combinational next-state logic for the tokenizer.
// Depends on flt_pkg (mode and kind codes, result struct).
module flt_lexer
  import flt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] ch_i,
  output result_t    res_o
);

  mode_e           mode_q, mode_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] word_start_q, word_start_d;
  logic [1:0]      word_len_q, word_len_d;
  logic            first_dot_q, first_dot_d;
  logic            last_quote_q, last_quote_d;
  logic [PosW-1:0] dq_start_q, dq_start_d;
  logic            is_dq;
  logic            sp;

  assign is_dq = (word_len_q == 2'd2) && first_dot_q && last_quote_q;
  assign sp    = is_space(ch_i);

  always_comb begin
    mode_d       = mode_q;
    pos_d        = (pos_q < PosCap) ? pos_q + PosW'(1) : PosCap;
    word_start_d = word_start_q;
    word_len_d   = word_len_q;
    first_dot_d  = first_dot_q;
    last_quote_d = last_quote_q;
    dq_start_d   = dq_start_q;
    res_o        = '{valid: 1'b0, kind: KIND_WORD, tok_start: pos_q, tok_end: pos_q};
    res_o.tok_start = word_start_q;

    if (ch_i == ChNul) begin
      // end of line: flush an open word, flag an open string
      if (mode_q == MODE_WORD) begin
        res_o.valid = 1'b1;
        res_o.kind  = is_dq ? KIND_DOTQUOTE : KIND_WORD;
      end else if (mode_q == MODE_STRING) begin
        res_o.valid = 1'b1;
        res_o.kind  = KIND_ERROR;
      end
      mode_d       = MODE_SKIP;
      pos_d        = '0;
      word_start_d = '0;
      word_len_d   = '0;
      first_dot_d  = 1'b0;
      last_quote_d = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_WORD: begin
          if (sp) begin
            res_o.valid = 1'b1;
            if (is_dq) begin
              res_o.kind = KIND_DOTQUOTE;
              dq_start_d = word_start_q;
              mode_d     = MODE_DQSKIP;
            end else begin
              res_o.kind = KIND_WORD;
              mode_d     = MODE_SKIP;
            end
          end else begin
            if (word_len_q != 2'd3) word_len_d = word_len_q + 2'd1;
            last_quote_d = (ch_i == ChQuote);
          end
        end
        MODE_DQSKIP: begin
          if (ch_i == ChQuote) begin
            res_o.valid     = 1'b1;
            res_o.kind      = KIND_EMPTY;
            res_o.tok_start = dq_start_q;
            res_o.tok_end   = dq_start_q;
            mode_d          = MODE_SKIP;
          end else if (!sp) begin
            word_start_d = pos_q;
            mode_d       = MODE_STRING;
          end
        end
        MODE_STRING: begin
          if (ch_i == ChQuote) begin
            res_o.valid = 1'b1;
            res_o.kind  = KIND_BODY;
            mode_d      = MODE_SKIP;
          end
        end
        MODE_SKIP: begin
          if (!sp) begin
            word_start_d = pos_q;
            word_len_d   = 2'd1;
            first_dot_d  = (ch_i == ChDot);
            last_quote_d = (ch_i == ChQuote);
            mode_d       = MODE_WORD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_SKIP;
      pos_q        <= '0;
      word_start_q <= '0;
      word_len_q   <= '0;
      first_dot_q  <= 1'b0;
      last_quote_q <= 1'b0;
      dq_start_q   <= '0;
    end else if (step_i) begin
      mode_q       <= mode_d;
      pos_q        <= pos_d;
      word_start_q <= word_start_d;
      word_len_q   <= word_len_d;
      first_dot_q  <= first_dot_d;
      last_quote_q <= last_quote_d;
      dq_start_q   <= dq_start_d;
    end
  end

endmodule

// ----- hw/rtl/forth_line_tokenizer_core.sv -----
// Forth line tokenizer: one character per transfer, at most one token per character.
// An accepted character is held in the input register; on advance its token loads the result register.
// Throughput: one character per cycle while out_stall_i is low; the lexer update is a single shallow step.
// A stalled result register holds the input register, which then stalls the input side.
// Reset (rst_ni low, async): lexer in skip mode, position and marks zero, no valid data.
// Depends on flt_pkg and flt_lexer.
module forth_line_tokenizer_core
  import flt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      ch_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      kind_o,
  output logic [PosW-1:0] tok_start_o,
  output logic [PosW-1:0] tok_end_o
);

  // input register
  logic            in_vld_q;
  logic [7:0]      in_ch_q;
  // result register
  logic            out_vld_q;
  kind_e           out_kind_q;
  logic [PosW-1:0] out_start_q;
  logic [PosW-1:0] out_end_q;

  logic    advance;
  logic    in_take;
  result_t res;

  // Advance the held character into the lexer whenever the result slot is
  // free or its current token is being transferred out this cycle.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  flt_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .ch_i   (in_ch_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_ch_q <= ch_i;
    end
  end

  // Drop the valid flag once the token is taken; load a new one on advance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res.valid;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_kind_q  <= res.kind;
      out_start_q <= res.tok_start;
      out_end_q   <= res.tok_end;
    end
  end

  assign out_valid_o = out_vld_q;
  assign kind_o      = out_kind_q;
  assign tok_start_o = out_start_q;
  assign tok_end_o   = out_end_q;

endmodule
